// ===== hw/rtl/totp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the TOTP verifier with replay window.
// No dependencies; imported by every module of the block.
package totp_pkg;

  localparam int unsigned MaxKeyBytes = 32;
  localparam int unsigned TimeW       = 40;
  localparam int unsigned CodeW       = 30;
  localparam int unsigned CfgDataW    = 64;
  localparam int unsigned CfgIdxW     = 3;

  typedef enum logic [CfgIdxW-1:0] {
    RegKeyWord0   = 3'd0,
    RegKeyWord1   = 3'd1,
    RegKeyWord2   = 3'd2,
    RegKeyWord3   = 3'd3,
    RegKeyLength  = 3'd4,
    RegStepPeriod = 3'd5,
    RegCodeDigits = 3'd6
  } reg_idx_e;

  localparam logic [1:0] OutcomeMatched = 2'd0;
  localparam logic [1:0] OutcomeTooOld  = 2'd1;
  localparam logic [1:0] OutcomeNoMatch = 2'd2;

  localparam logic [159:0] Sha1Iv =
    160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

  // 10^d for d = 1..9
  function automatic logic [CodeW-1:0] pow10(input logic [3:0] d);
    logic [CodeW-1:0] p;
    unique case (d)
      4'd1:    p = 30'd10;
      4'd2:    p = 30'd100;
      4'd3:    p = 30'd1000;
      4'd4:    p = 30'd10000;
      4'd5:    p = 30'd100000;
      4'd6:    p = 30'd1000000;
      4'd7:    p = 30'd10000000;
      4'd8:    p = 30'd100000000;
      default: p = 30'd1000000000;
    endcase
    return p;
  endfunction

endpackage

// ===== hw/rtl/totp_sha1_core.sv =====
`timescale 1ns / 1ps
// Iterative SHA-1 compression: one round per cycle.
// Depends on totp_pkg.
module totp_sha1_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [159:0] h_i,
  input  logic [511:0] block_i,
  output logic         done_o,
  output logic [159:0] digest_o
);
  import totp_pkg::*;

  logic [31:0]  w_q [16];
  logic [31:0]  a_q, b_q, c_q, d_q, e_q;
  logic [159:0] h_q, digest_q;
  logic [6:0]   rnd_q;
  logic         busy_q, done_q;
  logic [31:0]  wt, f, k, t;

  always_comb begin
    wt = (rnd_q < 7'd16) ? w_q[0]
       : {w_q[13][30:0] ^ w_q[8][30:0] ^ w_q[2][30:0] ^ w_q[0][30:0],
          w_q[13][31] ^ w_q[8][31] ^ w_q[2][31] ^ w_q[0][31]};
    if (rnd_q < 7'd20) begin
      f = (b_q & c_q) | (~b_q & d_q);
      k = 32'h5A827999;
    end else if (rnd_q < 7'd40) begin
      f = b_q ^ c_q ^ d_q;
      k = 32'h6ED9EBA1;
    end else if (rnd_q < 7'd60) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k = 32'h8F1BBCDC;
    end else begin
      f = b_q ^ c_q ^ d_q;
      k = 32'hCA62C1D6;
    end
    t = {a_q[26:0], a_q[31:27]} + f + e_q + k + wt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rnd_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        rnd_q  <= '0;
      end else if (busy_q) begin
        rnd_q <= rnd_q + 7'd1;
        if (rnd_q == 7'd79) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      h_q <= h_i;
      a_q <= h_i[159:128];
      b_q <= h_i[127:96];
      c_q <= h_i[95:64];
      d_q <= h_i[63:32];
      e_q <= h_i[31:0];
      for (int i = 0; i < 16; i++) begin
        w_q[i] <= block_i[511-32*i -: 32];
      end
    end else if (busy_q) begin
      a_q <= t;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[15] <= wt;
      if (rnd_q == 7'd79) begin
        digest_q <= {h_q[159:128] + t, h_q[127:96] + a_q,
                     h_q[95:64] + {b_q[1:0], b_q[31:2]},
                     h_q[63:32] + c_q, h_q[31:0] + d_q};
      end
    end
  end

  assign done_o   = done_q;
  assign digest_o = digest_q;
endmodule

// ===== hw/rtl/totp_divider.sv =====
`timescale 1ns / 1ps
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on totp_pkg for the operand widths.
module totp_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [totp_pkg::TimeW-1:0]  dividend_i,
  input  logic [totp_pkg::CodeW-1:0]  divisor_i,
  output logic                        done_o,
  output logic [totp_pkg::TimeW-1:0]  quot_o,
  output logic [totp_pkg::CodeW-1:0]  rem_o
);
  import totp_pkg::*;

  localparam int unsigned CntW = $clog2(TimeW + 1);

  logic [TimeW-1:0] quot_q;
  logic [CodeW-1:0] rem_q, div_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;
  logic [CodeW:0]   shifted, trial;
  logic             fits;

  always_comb begin
    shifted = {rem_q, quot_q[TimeW-1]};
    trial   = shifted - {1'b0, div_q};
    fits    = shifted >= {1'b0, div_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(TimeW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      div_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= fits ? trial[CodeW-1:0] : shifted[CodeW-1:0];
      quot_q <= {quot_q[TimeW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;
endmodule

// ===== hw/rtl/totp_verify_replay_window.sv =====
`timescale 1ns / 1ps
// TOTP verifier (HOTP over HMAC-SHA1, +/-1 step window, 3-bit replay mask).
// Each request transfer carries a time in seconds and a user code and yields
// one result transfer: accepted, outcome (matched / too old / no fresh match)
// and the matching step offset. The step is time / step_period, computed on a
// shared one-bit-per-cycle divider. Every candidate step inside the window and
// not yet set in the replay mask runs four SHA-1 compressions on a single
// round-per-cycle core and a modulo 10^digits on the same divider. The block
// takes one request at a time; a finished result waits in the output register
// while the next request is accepted.
// Configuration writes land immediately and must occur only while idle.
// Depends on totp_pkg, totp_sha1_core and totp_divider.
module totp_verify_replay_window (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [totp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [totp_pkg::CfgDataW-1:0]  cfg_data_i,
  // request stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [71:0]                    s_axis_tdata,  // time_seconds[39:0], entered_code[69:40]
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata   // accepted[0], outcome[2:1], matched_offset[4:3]
);
  import totp_pkg::*;

  typedef enum logic [3:0] {
    StIdle, StStepDiv, StWindow, StTry, StInner1, StInner2,
    StOuter1, StOuter2, StMod, StDone
  } state_e;

  state_e state_q;

  // configuration registers
  logic [63:0]       key_q [4];
  logic [5:0]        key_len_q;
  logic [11:0]       period_q;
  logic [3:0]        digits_q;

  // window state
  logic [TimeW-1:0]  base_q;
  logic [2:0]        mask_q;

  // request context
  logic [TimeW-1:0]  time_q, step_q;
  logic [CodeW-1:0]  code_q;
  logic [1:0]        off_q;   // signed candidate offset
  logic [1:0]        diff_q;  // signed step - base
  logic [159:0]      ih_q;
  logic              res_acc_q;
  logic [1:0]        res_outcome_q, res_off_q;

  // output register
  logic              out_valid_q;
  logic [4:0]        out_data_q;
  logic              out_load;

  // shared units
  logic              sha_start, sha_done, div_start, div_done;
  logic [159:0]      sha_h, sha_digest;
  logic [511:0]      sha_block;
  logic [TimeW-1:0]  div_a, div_quot;
  logic [CodeW-1:0]  div_b, div_rem;

  logic [511:0]      key_block;
  logic [255:0]      key_flat;
  logic [41:0]       cand;
  logic [63:0]       counter;
  logic [2:0]        slot;
  logic              slot_ok;
  logic [159:0]      mac_rot;
  logic [TimeW-1:0]  trunc_bin;
  logic [3:0]        digits_eff;
  logic [11:0]       period_eff;
  logic              new_window, too_old;

  // key padded to a full block; bytes at or past key_length read as zero
  always_comb begin
    key_flat  = {key_q[0], key_q[1], key_q[2], key_q[3]};
    key_block = '0;
    for (int i = 0; i < MaxKeyBytes; i++) begin
      if (6'(i) < key_len_q) begin
        key_block[511-8*i -: 8] = key_flat[255-8*i -: 8];
      end
    end
  end

  always_comb begin
    period_eff = (period_q == 12'd0) ? 12'd1 : period_q;
    digits_eff = (digits_q == 4'd0) ? 4'd1 : ((digits_q > 4'd9) ? 4'd9 : digits_q);
    new_window = (base_q == '0) || ({1'b0, step_q} > ({1'b0, base_q} + 41'd1));
    too_old    = ({1'b0, step_q} + 41'd1) < {1'b0, base_q};
    // candidate counter: step + offset, sign-extended to 64 bits
    cand       = {2'b00, step_q} + {{40{off_q[1]}}, off_q};
    counter    = {{22{cand[41]}}, cand};
    slot       = {off_q[1], off_q} + {diff_q[1], diff_q} + 3'd1;
    slot_ok    = !slot[2] && (slot[1:0] != 2'd3) && !mask_q[slot[1:0]];
    // dynamic truncation: byte offset from the low nibble of the last byte
    mac_rot    = sha_digest << {sha_digest[3:0], 3'b000};
    trunc_bin  = {9'd0, mac_rot[158:128]};
    // load the output register once it is empty or draining this cycle
    out_load   = (state_q == StDone) && (!out_valid_q || m_axis_tready);
  end

  // feed the SHA core per HMAC phase and the shared divider for step and modulo
  always_comb begin
    sha_start = 1'b0;
    sha_h     = Sha1Iv;
    sha_block = key_block ^ {64{8'h36}};
    div_start = 1'b0;
    div_a     = time_q;
    div_b     = {18'd0, period_eff};
    unique case (state_q)
      StIdle: begin
        div_start = s_axis_tvalid;
        div_a     = s_axis_tdata[TimeW-1:0];
      end
      StTry:    sha_start = slot_ok;
      StInner1: begin
        sha_start = sha_done;
        sha_h     = sha_digest;
        sha_block = {counter, 8'h80, 376'd0, 64'd576};
      end
      StInner2: begin
        sha_start = sha_done;
        sha_block = key_block ^ {64{8'h5C}};
      end
      StOuter1: begin
        sha_start = sha_done;
        sha_h     = sha_digest;
        sha_block = {ih_q, 8'h80, 280'd0, 64'd672};
      end
      StOuter2: begin
        div_start = sha_done;
        div_a     = trunc_bin;
        div_b     = pow10(digits_eff);
      end
      default: ;
    endcase
  end

  totp_sha1_core u_sha1 (
    .clk_i, .rst_ni,
    .start_i  (sha_start),
    .h_i      (sha_h),
    .block_i  (sha_block),
    .done_o   (sha_done),
    .digest_o (sha_digest)
  );

  totp_divider u_div (
    .clk_i, .rst_ni,
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q[0]  <= '0;
      key_q[1]  <= '0;
      key_q[2]  <= '0;
      key_q[3]  <= '0;
      key_len_q <= 6'd20;
      period_q  <= 12'd30;
      digits_q  <= 4'd6;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        RegKeyWord0:   key_q[0]  <= cfg_data_i;
        RegKeyWord1:   key_q[1]  <= cfg_data_i;
        RegKeyWord2:   key_q[2]  <= cfg_data_i;
        RegKeyWord3:   key_q[3]  <= cfg_data_i;
        RegKeyLength:  key_len_q <= cfg_data_i[5:0];
        RegStepPeriod: period_q  <= cfg_data_i[11:0];
        RegCodeDigits: digits_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      base_q        <= '0;
      mask_q        <= '0;
      out_valid_q   <= 1'b0;
      out_data_q    <= '0;
      time_q        <= '0;
      step_q        <= '0;
      code_q        <= '0;
      off_q         <= '0;
      diff_q        <= '0;
      ih_q          <= '0;
      res_acc_q     <= 1'b0;
      res_outcome_q <= OutcomeNoMatch;
      res_off_q     <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (s_axis_tvalid) begin
            time_q  <= s_axis_tdata[TimeW-1:0];
            code_q  <= s_axis_tdata[TimeW +: CodeW];
            state_q <= StStepDiv;
          end
        end
        StStepDiv: begin
          if (div_done) begin
            step_q  <= div_quot;
            state_q <= StWindow;
          end
        end
        StWindow: begin
          res_acc_q     <= 1'b0;
          res_outcome_q <= (!new_window && too_old) ? OutcomeTooOld : OutcomeNoMatch;
          res_off_q     <= '0;
          off_q         <= 2'b11;
          if (new_window) begin
            base_q  <= step_q;
            mask_q  <= '0;
            diff_q  <= '0;
            state_q <= StTry;
          end else if (too_old) begin
            state_q <= StDone;
          end else begin
            diff_q  <= step_q[1:0] - base_q[1:0];
            state_q <= StTry;
          end
        end
        StTry: begin
          if (slot_ok) begin
            state_q <= StInner1;
          end else if (off_q == 2'b01) begin
            state_q <= StDone;
          end else begin
            off_q <= off_q + 2'd1;
          end
        end
        StInner1: if (sha_done) state_q <= StInner2;
        StInner2: begin
          if (sha_done) begin
            ih_q    <= sha_digest;
            state_q <= StOuter1;
          end
        end
        StOuter1: if (sha_done) state_q <= StOuter2;
        StOuter2: if (sha_done) state_q <= StMod;
        StMod: begin
          if (div_done) begin
            if (div_rem == code_q) begin
              mask_q[slot[1:0]] <= 1'b1;
              res_acc_q         <= 1'b1;
              res_outcome_q     <= OutcomeMatched;
              res_off_q         <= off_q;
              state_q           <= StDone;
            end else if (off_q == 2'b01) begin
              state_q <= StDone;
            end else begin
              off_q   <= off_q + 2'd1;
              state_q <= StTry;
            end
          end
        end
        StDone: begin
          // hold the result until the output register is free
          if (out_load) begin
            out_data_q <= {res_off_q, res_outcome_q, res_acc_q};
            state_q    <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_data_q};

  // an accepted code always reports a match outcome
  a_acc_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[2:1] == OutcomeMatched))
    else $error("accepted result without matched outcome");

  // a rejected code carries no offset
  a_rej_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[4:3] == 2'b00))
    else $error("rejected result with nonzero offset");

  // a match sets exactly one new mask bit
  a_mask_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMod && div_done && div_rem == code_q)
      |=> ($countones(mask_q) == $countones($past(mask_q)) + 1))
    else $error("replay mask did not grow by one on a match");

endmodule
